>>> hw/rtl/tkrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkrt_pkg: shared types for the top-K ranked table
// Request and response payloads, the stored entry, and the offer and status
// bundles that run between the top level and each cell of the chain.
// ----------------------------------------------------------------------------
package tkrt_pkg;

  // request opcodes
  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // width of rank, count and read index fields
  localparam int RANK_W = 4;

  typedef struct packed {
    logic              cmd;
    logic [31:0]       score_in;
    logic [31:0]       time_in;
    logic [15:0]       tag_in;
    logic [RANK_W-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic              accepted;
    logic [RANK_W-1:0] rank;
    logic [RANK_W-1:0] count;
    logic              entry_valid;
    logic [31:0]       entry_score;
    logic [31:0]       entry_time;
    logic [15:0]       entry_tag;
  } rsp_t;

  // one stored table entry
  typedef struct packed {
    logic [31:0] score;
    logic [31:0] time_ms;
    logic [15:0] tag;
  } entry_t;

  // offer broadcast to every cell
  typedef struct packed {
    logic   en;
    entry_t item;
  } offer_t;

  // per-cell status back to the top level
  typedef struct packed {
    logic beats;   // stored entry is occupied and ranks strictly above the offer
    logic landed;  // the offer lands in this cell
  } cell_stat_t;

endpackage

>>> hw/rtl/tkrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkrt_cell: one rank slot of the sorted chain
// Holds one entry, compares it against the offered entry, and on an offer
// either keeps its entry, takes the offer, or takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module tkrt_cell #(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic                clk,
  input  tkrt_pkg::offer_t    offer,
  input  logic [CW-1:0]       count,
  input  tkrt_pkg::entry_t    nbr_entry,
  input  logic                nbr_beats,
  output tkrt_pkg::entry_t    entry,
  output tkrt_pkg::cell_stat_t stat
);

  logic occupied;
  logic ranks_above;

  // occupancy follows the entry count: slots fill from rank 0 down
  assign occupied = CW'(IDX) < count;

  // larger score wins, then larger time; a tie goes to the newcomer
  assign ranks_above = (entry.score > offer.item.score) ||
                       ((entry.score == offer.item.score) &&
                        (entry.time_ms > offer.item.time_ms));

  assign stat.beats  = occupied && ranks_above;
  assign stat.landed = !stat.beats && nbr_beats;

  // keep, insert, or shift down from the neighbor
  always_ff @(posedge clk) begin
    if (offer.en && !stat.beats) begin
      entry <= nbr_beats ? offer.item : nbr_entry;
    end
  end

endmodule

>>> hw/rtl/top_k_ranked_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_ranked_table: keeps the best TABLE_DEPTH entries in rank order
// Each accepted request's response is captured in the response register.
// Throughput: one request per cycle while the response side is not stalled;
// the chain compares and shifts together; a stalled response register holds.
// Reset clears count and rsp_valid; slot contents stay unset until written.
// ----------------------------------------------------------------------------
module top_k_ranked_table #(
  parameter int TABLE_DEPTH = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tkrt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tkrt_pkg::rsp_t rsp
);

  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int READ_N = (TABLE_DEPTH < 16) ? TABLE_DEPTH : 16;

  logic                 fire;
  logic                 offer_fire;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  tkrt_pkg::offer_t     offer;
  tkrt_pkg::entry_t     entries [TABLE_DEPTH];
  tkrt_pkg::entry_t     nbr     [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] beats;
  logic [TABLE_DEPTH-1:0] nbr_beats;
  logic [TABLE_DEPTH-1:0] landed;
  tkrt_pkg::cell_stat_t stats   [TABLE_DEPTH];
  logic                 accepted;
  logic                 grow;
  logic [tkrt_pkg::RANK_W-1:0] rank;
  tkrt_pkg::rsp_t       rsp_next;

  // request handshake: accept whenever the response register can move
  assign req_stall  = rsp_valid && rsp_stall;
  assign fire       = req_valid && !req_stall;
  assign offer_fire = fire && (req.cmd == tkrt_pkg::OP_OFFER);

  assign offer.en           = offer_fire;
  assign offer.item.score   = req.score_in;
  assign offer.item.time_ms = req.time_in;
  assign offer.item.tag     = req.tag_in;

  // cell chain: each cell sees its upper neighbor
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign nbr[i]       = offer.item;
      assign nbr_beats[i] = 1'b1;
    end else begin : g_body
      assign nbr[i]       = entries[i-1];
      assign nbr_beats[i] = beats[i-1];
    end

    tkrt_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .offer     (offer),
      .count     (count),
      .nbr_entry (nbr[i]),
      .nbr_beats (nbr_beats[i]),
      .entry     (entries[i]),
      .stat      (stats[i])
    );

    assign beats[i]  = stats[i].beats;
    assign landed[i] = stats[i].landed;
  end

  // the offer gets in unless every slot beats it
  assign accepted = !beats[TABLE_DEPTH-1];
  assign grow     = offer_fire && accepted && (count < CW'(TABLE_DEPTH));

  // landing slot index
  always_comb begin
    rank = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (landed[i]) begin
        rank = rank | tkrt_pkg::RANK_W'(i);
      end
    end
  end

  // response assembly
  always_comb begin
    rsp_next = '0;
    if (req.cmd == tkrt_pkg::OP_OFFER) begin
      rsp_next.accepted = accepted;
      rsp_next.rank     = accepted ? rank : '0;
    end else begin
      for (int i = 0; i < READ_N; i++) begin
        if ((req.read_index == tkrt_pkg::RANK_W'(i)) && (CW'(i) < count)) begin
          rsp_next.entry_valid = 1'b1;
          rsp_next.entry_score = entries[i].score;
          rsp_next.entry_time  = entries[i].time_ms;
          rsp_next.entry_tag   = entries[i].tag;
        end
      end
    end
    rsp_next.count = tkrt_pkg::RANK_W'(count_next);
  end

  assign count_next = grow ? count + CW'(1) : count;

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

`ifndef ASSERT_OFF
  // count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // the offer lands in at most one slot
  a_one_landing: assert property (@(posedge clk) disable iff (rst)
    $onehot0(landed))
    else $error("offer landed in more than one slot");

  // an offer into a table with room is always taken
  a_room_accepts: assert property (@(posedge clk) disable iff (rst)
    offer_fire && (count < CW'(TABLE_DEPTH)) |=> rsp.accepted)
    else $error("offer rejected while table had room");

  // a rejection only happens on a full table
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    offer_fire && !accepted |-> count == CW'(TABLE_DEPTH))
    else $error("offer rejected on a table that is not full");

  // count moves only on an accepted request
  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(count))
    else $error("entry count changed without a request");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for top_k_ranked_table
// Drives offer and read requests through the valid/stall request channel and
// checks every response against a behavioral copy of the ranked table. A
// short table of directed requests covers the empty table, extreme values,
// ties and rejection, then random requests shaped around the stored entries.
// Both channels idle at random, except over one long stretch.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH        = 10;
  localparam int RANDOM_ITEMS = 1226;
  localparam int CALM_FIRST   = 500;
  localparam int CALM_LAST    = 800;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int MAX_PRINTS   = 50;
  localparam int RESULT_SLOTS = 64;
  localparam int DIR_MAX      = 32;

  typedef struct {
    tkrt_pkg::req_t r;
    bit             typed;
    tkrt_pkg::rsp_t want;
  } dir_row_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           rsp_stall = 1'b0;
  tkrt_pkg::req_t req       = '0;
  logic           req_stall;
  logic           rsp_valid;
  tkrt_pkg::rsp_t rsp;

  // the typed expectation travels with the request it belongs to
  logic           req_typed = 1'b0;
  tkrt_pkg::rsp_t req_want  = '0;

  // shadow of the ranked table, best entry first
  tkrt_pkg::entry_t ranked[DEPTH];
  int               held = 0;

  // expected responses in order, as a ring with running write/read counts
  tkrt_pkg::rsp_t result_q[RESULT_SLOTS];
  int             q_wr = 0;
  int             q_rd = 0;

  dir_row_t dir_rows[DIR_MAX];
  int       n_rows = 0;
  bit       calm = 1'b0;
  int       mismatches = 0;
  int       cycles = 0;
  int       n_offers = 0, n_taken = 0, n_reads = 0, n_hits = 0, n_results = 0;

  top_k_ranked_table #(.TABLE_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // one request against the shadow table; returns the response it should give
  function automatic tkrt_pkg::rsp_t rank_table_step(tkrt_pkg::req_t r);
    tkrt_pkg::rsp_t o;
    int   pos;
    int   last;
    o = '0;
    if (r.cmd == tkrt_pkg::OP_OFFER) begin
      pos = 0;
      // land below every entry that strictly outranks the offer
      while (pos < held && (ranked[pos].score > r.score_in ||
             (ranked[pos].score == r.score_in && ranked[pos].time_ms > r.time_in)))
        pos++;
      if (pos < DEPTH) begin
        last = (held < DEPTH) ? held : DEPTH - 1;
        for (int k = last; k > pos; k--)
          ranked[k] = ranked[k-1];
        ranked[pos] = '{score: r.score_in, time_ms: r.time_in, tag: r.tag_in};
        if (held < DEPTH)
          held++;
        o.accepted = 1'b1;
        o.rank     = tkrt_pkg::RANK_W'(pos);
      end
    end else if (r.read_index < held) begin
      o.entry_valid = 1'b1;
      o.entry_score = ranked[r.read_index].score;
      o.entry_time  = ranked[r.read_index].time_ms;
      o.entry_tag   = ranked[r.read_index].tag;
    end
    o.count = tkrt_pkg::RANK_W'(held);
    return o;
  endfunction

  function automatic tkrt_pkg::req_t make_offer(logic [31:0] s, logic [31:0] t,
                                                logic [15:0] g);
    tkrt_pkg::req_t r;
    r = '0;
    r.cmd      = tkrt_pkg::OP_OFFER;
    r.score_in = s;
    r.time_in  = t;
    r.tag_in   = g;
    return r;
  endfunction

  function automatic tkrt_pkg::req_t make_read(logic [tkrt_pkg::RANK_W-1:0] idx);
    tkrt_pkg::req_t r;
    r = '0;
    r.cmd        = tkrt_pkg::OP_READ;
    r.read_index = idx;
    return r;
  endfunction

  function automatic tkrt_pkg::rsp_t make_result(logic acc, logic [tkrt_pkg::RANK_W-1:0] rk,
                                                 logic [tkrt_pkg::RANK_W-1:0] cnt, logic vld,
                                                 logic [31:0] s, logic [31:0] t,
                                                 logic [15:0] g);
    tkrt_pkg::rsp_t o;
    o.accepted    = acc;
    o.rank        = rk;
    o.count       = cnt;
    o.entry_valid = vld;
    o.entry_score = s;
    o.entry_time  = t;
    o.entry_tag   = g;
    return o;
  endfunction

  // random request, mostly offers, many aimed at the scores already held
  function automatic tkrt_pkg::req_t random_request();
    tkrt_pkg::req_t r;
    int   p;
    r.cmd        = ($urandom_range(0, 99) < 25) ? tkrt_pkg::OP_READ : tkrt_pkg::OP_OFFER;
    r.score_in   = $urandom;
    r.time_in    = $urandom;
    r.tag_in     = 16'($urandom_range(0, 65535));
    r.read_index = tkrt_pkg::RANK_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                                 : $urandom_range(0, DEPTH - 1));
    if (r.cmd == tkrt_pkg::OP_OFFER && held > 0) begin
      p = $urandom_range(0, held - 1);
      case ($urandom_range(0, 9))
        0, 1: ;  // fully random
        2, 3: begin
          r.score_in = ranked[p].score + $urandom_range(0, 2) - 1;
          if ($urandom_range(0, 1))
            r.time_in = ranked[p].time_ms;
        end
        4: begin  // exact tie with the worst entry
          r.score_in = ranked[held-1].score;
          r.time_in  = ranked[held-1].time_ms;
        end
        5: begin  // just below the worst entry
          r.score_in = ranked[held-1].score;
          r.time_in  = ranked[held-1].time_ms - 1;
        end
        6: r.score_in = '1;
        7: r.score_in = '0;
        default: begin
          r.score_in = $urandom_range(0, 63);
          r.time_in  = $urandom_range(0, 15);
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatches < MAX_PRINTS)
      $display("MISMATCH at %0t, response %0d, %s: got %0h, expected %0h",
               $realtime, n_results, what, got, want);
    mismatches++;
  endtask

  // hold each request until the block takes it; idles first at random
  task automatic send_request(tkrt_pkg::req_t r, bit typed, tkrt_pkg::rsp_t want);
    while (!calm && $urandom_range(0, 99) < 34) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_typed <= typed;
    req_want  <= want;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // response side stalls at random
  always @(posedge clk) begin
    rsp_stall <= !calm && ($urandom_range(0, 99) < 34);
  end

  // predict on each accepted request, compare each accepted response
  always @(posedge clk) begin : watch
    tkrt_pkg::rsp_t predicted;
    tkrt_pkg::rsp_t oldest;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        predicted = rank_table_step(req);
        if (req.cmd == tkrt_pkg::OP_OFFER) begin
          n_offers++;
          if (predicted.accepted) n_taken++;
        end else begin
          n_reads++;
          if (predicted.entry_valid) n_hits++;
        end
        result_q[q_wr % RESULT_SLOTS] = req_typed ? req_want : predicted;
        q_wr++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (q_wr == q_rd) begin
          report_mismatch("response with nothing outstanding", 1, 0);
        end else begin
          oldest = result_q[q_rd % RESULT_SLOTS];
          q_rd++;
          if (rsp.accepted !== oldest.accepted)
            report_mismatch("accepted", rsp.accepted, oldest.accepted);
          if (rsp.rank !== oldest.rank)
            report_mismatch("rank", rsp.rank, oldest.rank);
          if (rsp.count !== oldest.count)
            report_mismatch("count", rsp.count, oldest.count);
          if (rsp.entry_valid !== oldest.entry_valid)
            report_mismatch("entry_valid", rsp.entry_valid, oldest.entry_valid);
          if (rsp.entry_score !== oldest.entry_score)
            report_mismatch("entry_score", rsp.entry_score, oldest.entry_score);
          if (rsp.entry_time !== oldest.entry_time)
            report_mismatch("entry_time", rsp.entry_time, oldest.entry_time);
          if (rsp.entry_tag !== oldest.entry_tag)
            report_mismatch("entry_tag", rsp.entry_tag, oldest.entry_tag);
        end
        n_results++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding",
               cycles, q_wr - q_rd);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // directed rows: row gets a typed result where it is obvious, else predicted
  task automatic add_row(tkrt_pkg::req_t r, bit typed = 1'b0, tkrt_pkg::rsp_t want = '0);
    dir_row_t row;
    row.r     = r;
    row.typed = typed;
    row.want  = want;
    dir_rows[n_rows] = row;
    n_rows++;
  endtask

  initial begin : stimulus
    dir_row_t row;
    // empty table
    add_row(make_read(0), 1, make_result(0, 0, 0, 0, 0, 0, 0));
    add_row(make_read(15), 1, make_result(0, 0, 0, 0, 0, 0, 0));
    // extremes
    add_row(make_offer('1, '1, 16'hffff), 1, make_result(1, 0, 1, 0, 0, 0, 0));
    add_row(make_read(0), 1, make_result(0, 0, 1, 1, '1, '1, 16'hffff));
    add_row(make_offer(0, 0, 0), 1, make_result(1, 1, 2, 0, 0, 0, 0));
    // score ties: later time ranks higher, full tie puts the newcomer first
    add_row(make_offer(100, 5, 1));
    add_row(make_offer(100, 9, 2));
    add_row(make_offer(100, 9, 3));
    // fill the table
    for (int i = 0; i < 5; i++)
      add_row(make_offer(200 + 100 * i, i, 16'(16 + i)));
    add_row(make_read(tkrt_pkg::RANK_W'(DEPTH - 1)));
    // full table: tie with the worst gets in, a worse one is rejected
    add_row(make_offer(0, 0, 7));
    add_row(make_offer(1, 0, 8));
    add_row(make_offer(0, '1, 9), 1, make_result(0, 0, 10, 0, 0, 0, 0));
    add_row(make_offer(1, 0, 10));
    // reads past the count
    add_row(make_read(10), 1, make_result(0, 0, 10, 0, 0, 0, 0));
    add_row(make_read(15), 1, make_result(0, 0, 10, 0, 0, 0, 0));
    // new best tied with the old best lands on top
    add_row(make_offer('1, '1, 16'h1234), 1, make_result(1, 0, 10, 0, 0, 0, 0));
    add_row(make_read(0), 1, make_result(0, 0, 10, 1, '1, '1, 16'h1234));
    add_row(make_read(1), 1, make_result(0, 0, 10, 1, '1, '1, 16'hffff));
    add_row(make_read(tkrt_pkg::RANK_W'(DEPTH - 1)));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < n_rows; i++) begin
      row = dir_rows[i];
      send_request(row.r, row.typed, row.want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      send_request(random_request(), 1'b0, '0);
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    // drain, then keep the clock running to catch stray responses
    while (q_wr != q_rd) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d offers (%0d taken), %0d reads (%0d hit a stored entry)",
             n_offers, n_taken, n_reads, n_hits);
    $display("Checked %0d responses in %0d cycles, %0d mismatches",
             n_results, cycles, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
